// ===== rtl/core/tsa_pkg.sv =====
// Shared types, widths and codes for the triangle stiffness assembly block.
package tsa_pkg;

    localparam int NODES_DEFAULT = 64;
    localparam int NODE_W = 6;
    localparam int COORD_W = 16;
    localparam int DIFF_W = 17;
    localparam int PROD_W = 34;
    localparam int DET_W = 35;
    localparam int VAL_W = 32;
    localparam int QUO_W = 35;
    localparam int DIV_W = 70;
    localparam int BPROD_W = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [VAL_W-1:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_DEGEN = 2'd1;
    localparam logic [1:0] STATUS_SAT = 2'd2;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_BOUND = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [DIFF_W-1:0]  b0;
        logic signed [DIFF_W-1:0]  b1;
        logic signed [DIFF_W-1:0]  b2;
        logic signed [DIFF_W-1:0]  c0;
        logic signed [DIFF_W-1:0]  c1;
        logic signed [DIFF_W-1:0]  c2;
        logic [NODE_W-1:0]         n0;
        logic [NODE_W-1:0]         n1;
        logic [NODE_W-1:0]         n2;
        logic                      ok0;
        logic                      ok1;
        logic                      ok2;
        logic signed [VAL_W-1:0]   voltage;
    } item_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DET0,
        S_DET1,
        S_DET2,
        S_NUM0,
        S_NUM1,
        S_NUM2,
        S_DIVINIT,
        S_DIV,
        S_KE,
        S_ACCRD,
        S_ACCWR,
        S_ACCNEXT,
        S_BINIT,
        S_BRD,
        S_BMUL,
        S_BSUB,
        S_BROW,
        S_RDREQ,
        S_RDDATA,
        S_DONE
    } seq_state_t;

endpackage

// ===== rtl/core/tsa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module tsa_ram
    import tsa_pkg::*;
#(
    parameter int WIDTH = VAL_W,
    parameter int DEPTH = NODES_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tsa_front.sv =====
// Front end: accepts transactions, forms edge differences and node range flags.
module tsa_front
    import tsa_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
)
(
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic [1:0]                mode,
    input  logic signed [COORD_W-1:0] x_first,
    input  logic signed [COORD_W-1:0] y_first,
    input  logic signed [COORD_W-1:0] x_second,
    input  logic signed [COORD_W-1:0] y_second,
    input  logic signed [COORD_W-1:0] x_third,
    input  logic signed [COORD_W-1:0] y_third,
    input  logic [NODE_W-1:0]         node_first,
    input  logic [NODE_W-1:0]         node_second,
    input  logic [NODE_W-1:0]         node_third,
    input  logic signed [VAL_W-1:0]   voltage,
    input  logic                      clearing,
    input  logic                      queue_full,
    output logic                      push,
    output item_t                     entry
);

    assign item_stall = queue_full || clearing;
    assign push = item_valid && !item_stall;

    always_comb
    begin
        entry.mode = mode_t'(mode);
        entry.b0 = DIFF_W'(y_second) - DIFF_W'(y_third);
        entry.b1 = DIFF_W'(y_third) - DIFF_W'(y_first);
        entry.b2 = DIFF_W'(y_first) - DIFF_W'(y_second);
        entry.c0 = DIFF_W'(x_third) - DIFF_W'(x_second);
        entry.c1 = DIFF_W'(x_first) - DIFF_W'(x_third);
        entry.c2 = DIFF_W'(x_second) - DIFF_W'(x_first);
        entry.n0 = node_first;
        entry.n1 = node_second;
        entry.n2 = node_third;
        entry.ok0 = 32'(node_first) < 32'(NODES);
        entry.ok1 = 32'(node_second) < 32'(NODES);
        entry.ok2 = 32'(node_third) < 32'(NODES);
        entry.voltage = voltage;
    end

endmodule

// ===== rtl/core/tsa_queue.sv =====
// Two-entry queue between the front end and the sequencer.
module tsa_queue
    import tsa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_data,
    input  logic  pop,
    output item_t head,
    output logic  empty,
    output logic  full
);

    item_t slot_reg [QUEUE_DEPTH];
    logic  wr_ptr_reg;
    logic  rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty = count_reg == 2'd0;
    assign full = count_reg == 2'(QUEUE_DEPTH);
    assign head = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/tsa_back.sv =====
// Back end: sequencer for element matrices, boundary nodes, reads and the clearing pass.
module tsa_back
    import tsa_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    queue_empty,
    input  item_t                   queue_head,
    output logic                    queue_pop,
    output logic                    clearing,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic signed [VAL_W-1:0] matrix_entry,
    output logic signed [VAL_W-1:0] load_entry,
    output logic [1:0]              status
);

    localparam int DEPTH = NODES * NODES;
    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(NODES);

    seq_state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic out_valid_reg, out_valid_next;

    item_t item_reg, item_next;
    logic signed [PROD_W-1:0] mul_reg, mul_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [DET_W-1:0] det_reg, det_next;
    logic signed [DET_W-1:0] num_reg, num_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsh_reg, dsh_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [5:0] cnt_reg, cnt_next;
    logic neg_reg, neg_next;
    logic signed [VAL_W-1:0] ke_reg, ke_next;
    logic sat_reg, sat_next;
    logic [1:0] pi_reg, pi_next;
    logic [1:0] pj_reg, pj_next;
    logic [LW-1:0] jn_reg, jn_next;
    logic signed [BPROD_W-1:0] prod_reg, prod_next;
    logic [VAL_W-1:0] ldh_reg, ldh_next;
    logic [VAL_W-1:0] res_mat_reg, res_mat_next;
    logic [VAL_W-1:0] res_ld_reg, res_ld_next;
    logic [1:0] res_st_reg, res_st_next;
    logic [VAL_W-1:0] out_mat_reg, out_mat_next;
    logic [VAL_W-1:0] out_ld_reg, out_ld_next;
    logic [1:0] out_st_reg, out_st_next;

    logic mat_we;
    logic [AW-1:0] mat_waddr;
    logic [VAL_W-1:0] mat_wdata;
    logic [AW-1:0] mat_raddr;
    logic [VAL_W-1:0] mat_rdata;
    logic ld_we;
    logic [LW-1:0] ld_waddr;
    logic [VAL_W-1:0] ld_wdata;
    logic [LW-1:0] ld_raddr;
    logic [VAL_W-1:0] ld_rdata;

    logic signed [DIFF_W-1:0] mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [BPROD_W-1:0] bmul;

    logic [DET_W-1:0] num_mag;
    logic [DET_W-1:0] det_mag;
    logic signed [VAL_W:0] acc_sum;
    logic [BPROD_W-1:0] pmag;
    logic [BPROD_W-1:0] prnd;
    logic [47:0] psgn;
    logic [48:0] ldiff;

    function automatic logic signed [DIFF_W-1:0] pick_b(input item_t t, input logic [1:0] k);
        logic signed [DIFF_W-1:0] r;
        case (k)
            2'd0: r = t.b0;
            2'd1: r = t.b1;
            default: r = t.b2;
        endcase
        return r;
    endfunction

    function automatic logic signed [DIFF_W-1:0] pick_c(input item_t t, input logic [1:0] k);
        logic signed [DIFF_W-1:0] r;
        case (k)
            2'd0: r = t.c0;
            2'd1: r = t.c1;
            default: r = t.c2;
        endcase
        return r;
    endfunction

    function automatic logic [NODE_W-1:0] pick_n(input item_t t, input logic [1:0] k);
        logic [NODE_W-1:0] r;
        case (k)
            2'd0: r = t.n0;
            2'd1: r = t.n1;
            default: r = t.n2;
        endcase
        return r;
    endfunction

    function automatic logic pick_ok(input item_t t, input logic [1:0] k);
        logic r;
        case (k)
            2'd0: r = t.ok0;
            2'd1: r = t.ok1;
            default: r = t.ok2;
        endcase
        return r;
    endfunction

    function automatic logic [AW-1:0] mat_addr(input logic [31:0] r, input logic [31:0] c);
        return AW'(r * NODES + c);
    endfunction

    tsa_ram #(
        .WIDTH(VAL_W),
        .DEPTH(DEPTH)
    ) u_mat_ram (
        .clk  (clk),
        .we   (mat_we),
        .waddr(mat_waddr),
        .wdata(mat_wdata),
        .raddr(mat_raddr),
        .rdata(mat_rdata)
    );

    tsa_ram #(
        .WIDTH(VAL_W),
        .DEPTH(NODES)
    ) u_load_ram (
        .clk  (clk),
        .we   (ld_we),
        .waddr(ld_waddr),
        .wdata(ld_wdata),
        .raddr(ld_raddr),
        .rdata(ld_rdata)
    );

    assign mul_p = mul_a * mul_b;
    assign bmul = $signed(mat_rdata) * item_reg.voltage;

    assign clearing = state_reg == S_CLEAR;
    assign result_valid = out_valid_reg;
    assign matrix_entry = out_mat_reg;
    assign load_entry = out_ld_reg;
    assign status = out_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        mul_reg <= mul_next;
        acc_reg <= acc_next;
        det_reg <= det_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        ke_reg <= ke_next;
        sat_reg <= sat_next;
        pi_reg <= pi_next;
        pj_reg <= pj_next;
        jn_reg <= jn_next;
        prod_reg <= prod_next;
        ldh_reg <= ldh_next;
        res_mat_reg <= res_mat_next;
        res_ld_reg <= res_ld_next;
        res_st_reg <= res_st_next;
        out_mat_reg <= out_mat_next;
        out_ld_reg <= out_ld_next;
        out_st_reg <= out_st_next;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        out_valid_next = out_valid_reg;
        item_next = item_reg;
        mul_next = mul_reg;
        acc_next = acc_reg;
        det_next = det_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        ke_next = ke_reg;
        sat_next = sat_reg;
        pi_next = pi_reg;
        pj_next = pj_reg;
        jn_next = jn_reg;
        prod_next = prod_reg;
        ldh_next = ldh_reg;
        res_mat_next = res_mat_reg;
        res_ld_next = res_ld_reg;
        res_st_next = res_st_reg;
        out_mat_next = out_mat_reg;
        out_ld_next = out_ld_reg;
        out_st_next = out_st_reg;

        queue_pop = 1'b0;
        mat_we = 1'b0;
        mat_waddr = '0;
        mat_wdata = '0;
        mat_raddr = '0;
        ld_we = 1'b0;
        ld_waddr = '0;
        ld_wdata = '0;
        ld_raddr = '0;
        mul_a = '0;
        mul_b = '0;

        num_mag = num_reg[DET_W-1] ? DET_W'(-num_reg) : DET_W'(num_reg);
        det_mag = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
        acc_sum = (VAL_W+1)'($signed(mat_rdata)) + (VAL_W+1)'(ke_reg);
        pmag = prod_reg[BPROD_W-1] ? (BPROD_W'(0) - BPROD_W'(prod_reg))
                                   : BPROD_W'(prod_reg);
        prnd = (pmag + BPROD_W'(32768)) >> 16;
        psgn = prod_reg[BPROD_W-1] ? (48'd0 - prnd[47:0]) : prnd[47:0];
        ldiff = {{17{ldh_reg[VAL_W-1]}}, ldh_reg} - {psgn[47], psgn};

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mat_we = 1'b1;
                mat_waddr = clr_reg;
                ld_we = 32'(clr_reg) < 32'(NODES);
                ld_waddr = LW'(clr_reg);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    queue_pop = 1'b1;
                    item_next = queue_head;
                    sat_next = 1'b0;
                    res_mat_next = '0;
                    res_ld_next = '0;
                    res_st_next = STATUS_OK;
                    case (queue_head.mode)
                        MODE_ADD: state_next = S_DET0;
                        MODE_BOUND: state_next = queue_head.ok0 ? S_BINIT : S_DONE;
                        MODE_READ: state_next = S_RDREQ;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_DET0:
            begin
                mul_a = item_reg.b0;
                mul_b = item_reg.c1;
                mul_next = mul_p;
                state_next = S_DET1;
            end
            S_DET1:
            begin
                mul_a = item_reg.b1;
                mul_b = item_reg.c0;
                acc_next = mul_reg;
                mul_next = mul_p;
                state_next = S_DET2;
            end
            S_DET2:
            begin
                det_next = DET_W'(acc_reg) - DET_W'(mul_reg);
                pi_next = 2'd0;
                pj_next = 2'd0;
                if (acc_reg == mul_reg)
                begin
                    res_st_next = STATUS_DEGEN;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_NUM0;
                end
            end
            S_NUM0:
            begin
                mul_a = pick_b(item_reg, pi_reg);
                mul_b = pick_b(item_reg, pj_reg);
                mul_next = mul_p;
                state_next = S_NUM1;
            end
            S_NUM1:
            begin
                mul_a = pick_c(item_reg, pi_reg);
                mul_b = pick_c(item_reg, pj_reg);
                acc_next = mul_reg;
                mul_next = mul_p;
                state_next = S_NUM2;
            end
            S_NUM2:
            begin
                num_next = DET_W'(acc_reg) + DET_W'(mul_reg);
                state_next = S_DIVINIT;
            end
            S_DIVINIT:
            begin
                rem_next = (DIV_W'(num_mag) << 16) + DIV_W'(det_mag);
                dsh_next = DIV_W'(det_mag) << QUO_W;
                quo_next = '0;
                cnt_next = 6'(QUO_W - 1);
                neg_next = num_reg[DET_W-1] ^ det_reg[DET_W-1];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                if (cnt_reg == 6'd0)
                begin
                    state_next = S_KE;
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            S_KE:
            begin
                if (!neg_reg)
                begin
                    if (quo_reg > QUO_W'(VAL_MAX))
                    begin
                        ke_next = VAL_MAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        ke_next = quo_reg[VAL_W-1:0];
                    end
                end
                else
                begin
                    if (quo_reg > QUO_W'(33'h1_0000_0000 >> 1))
                    begin
                        ke_next = VAL_MIN;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        ke_next = ~quo_reg[VAL_W-1:0] + 32'd1;
                    end
                end
                state_next = S_ACCRD;
            end
            S_ACCRD:
            begin
                mat_raddr = mat_addr(32'(pick_n(item_reg, pi_reg)),
                                     32'(pick_n(item_reg, pj_reg)));
                if (pick_ok(item_reg, pi_reg) && pick_ok(item_reg, pj_reg))
                begin
                    state_next = S_ACCWR;
                end
                else
                begin
                    state_next = S_ACCNEXT;
                end
            end
            S_ACCWR:
            begin
                mat_we = 1'b1;
                mat_waddr = mat_addr(32'(pick_n(item_reg, pi_reg)),
                                     32'(pick_n(item_reg, pj_reg)));
                if (acc_sum[VAL_W] != acc_sum[VAL_W-1])
                begin
                    mat_wdata = acc_sum[VAL_W] ? VAL_MIN : VAL_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    mat_wdata = acc_sum[VAL_W-1:0];
                end
                state_next = S_ACCNEXT;
            end
            S_ACCNEXT:
            begin
                if (pj_reg == 2'd2)
                begin
                    pj_next = 2'd0;
                    if (pi_reg == 2'd2)
                    begin
                        res_st_next = sat_reg ? STATUS_SAT : STATUS_OK;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pi_next = pi_reg + 2'd1;
                        state_next = S_NUM0;
                    end
                end
                else
                begin
                    pj_next = pj_reg + 2'd1;
                    state_next = S_NUM0;
                end
            end
            S_BINIT:
            begin
                ld_we = 1'b1;
                ld_waddr = LW'(item_reg.n0);
                ld_wdata = item_reg.voltage;
                mat_we = 1'b1;
                mat_waddr = mat_addr(32'(item_reg.n0), 32'(item_reg.n0));
                mat_wdata = ONE_Q16;
                jn_next = '0;
                state_next = S_BRD;
            end
            S_BRD:
            begin
                mat_raddr = mat_addr(32'(jn_reg), 32'(item_reg.n0));
                ld_raddr = jn_reg;
                if (32'(jn_reg) != 32'(item_reg.n0))
                begin
                    state_next = S_BMUL;
                end
                else if (jn_reg == LW'(NODES - 1))
                begin
                    res_st_next = sat_reg ? STATUS_SAT : STATUS_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    jn_next = jn_reg + LW'(1);
                end
            end
            S_BMUL:
            begin
                prod_next = bmul;
                ldh_next = ld_rdata;
                state_next = S_BSUB;
            end
            S_BSUB:
            begin
                ld_we = 1'b1;
                ld_waddr = jn_reg;
                if ((ldiff[48:31] == '0) || (ldiff[48:31] == '1))
                begin
                    ld_wdata = ldiff[VAL_W-1:0];
                end
                else
                begin
                    ld_wdata = ldiff[48] ? VAL_MIN : VAL_MAX;
                    sat_next = 1'b1;
                end
                mat_we = 1'b1;
                mat_waddr = mat_addr(32'(jn_reg), 32'(item_reg.n0));
                state_next = S_BROW;
            end
            S_BROW:
            begin
                mat_we = 1'b1;
                mat_waddr = mat_addr(32'(item_reg.n0), 32'(jn_reg));
                if (jn_reg == LW'(NODES - 1))
                begin
                    res_st_next = sat_reg ? STATUS_SAT : STATUS_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    jn_next = jn_reg + LW'(1);
                    state_next = S_BRD;
                end
            end
            S_RDREQ:
            begin
                mat_raddr = mat_addr(32'(item_reg.n0), 32'(item_reg.n1));
                ld_raddr = LW'(item_reg.n0);
                state_next = S_RDDATA;
            end
            S_RDDATA:
            begin
                res_mat_next = (item_reg.ok0 && item_reg.ok1) ? mat_rdata : '0;
                res_ld_next = item_reg.ok0 ? ld_rdata : '0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    out_mat_next = res_mat_reg;
                    out_ld_next = res_ld_reg;
                    out_st_next = res_st_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/triangle_stiffness_assembly.sv =====
// Top level: Laplace stiffness matrix and load vector assembly for linear triangles.
// Add-triangle transaction: a determinant, then a 35-step divider per element entry.
// Boundary-node transaction: a walk over the boundary node's column and row.
// Read transaction: one matrix and one load entry. One transaction is worked at a time;
// two may queue. After reset a clearing pass over all NODES * NODES entries zeroes both
// stores; no transaction is taken during it.
module triangle_stiffness_assembly
    import tsa_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic [1:0]                mode,
    input  logic signed [COORD_W-1:0] x_first,
    input  logic signed [COORD_W-1:0] y_first,
    input  logic signed [COORD_W-1:0] x_second,
    input  logic signed [COORD_W-1:0] y_second,
    input  logic signed [COORD_W-1:0] x_third,
    input  logic signed [COORD_W-1:0] y_third,
    input  logic [NODE_W-1:0]         node_first,
    input  logic [NODE_W-1:0]         node_second,
    input  logic [NODE_W-1:0]         node_third,
    input  logic signed [VAL_W-1:0]   voltage,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic signed [VAL_W-1:0]   matrix_entry,
    output logic signed [VAL_W-1:0]   load_entry,
    output logic [1:0]                status
);

    logic  clearing;
    logic  queue_full;
    logic  queue_empty;
    logic  push;
    logic  pop;
    item_t entry;
    item_t head;

    tsa_front #(
        .NODES(NODES)
    ) u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .mode       (mode),
        .x_first    (x_first),
        .y_first    (y_first),
        .x_second   (x_second),
        .y_second   (y_second),
        .x_third    (x_third),
        .y_third    (y_third),
        .node_first (node_first),
        .node_second(node_second),
        .node_third (node_third),
        .voltage    (voltage),
        .clearing   (clearing),
        .queue_full (queue_full),
        .push       (push),
        .entry      (entry)
    );

    tsa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(entry),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    tsa_back #(
        .NODES(NODES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_head  (head),
        .queue_pop   (pop),
        .clearing    (clearing),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .matrix_entry(matrix_entry),
        .load_entry  (load_entry),
        .status      (status)
    );

endmodule

// ===== test/tb_triangle_stiffness_assembly.sv =====
// Testbench for the triangle stiffness assembly block with a built-in matrix and load predictor.
`timescale 1ns / 1ps

module tb_triangle_stiffness_assembly;
    import tsa_pkg::*;

    typedef struct {
        logic [1:0]         mode;
        logic signed [15:0] xa, ya, xb, yb, xc, yc;
        logic [5:0]         na, nb, nc;
        logic signed [31:0] volt;
    } txn_t;

    typedef struct {
        logic signed [31:0] mat;
        logic signed [31:0] ld;
        logic [1:0]         st;
    } res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic [1:0] mode = '0;
    logic signed [15:0] x_first = '0, y_first = '0, x_second = '0;
    logic signed [15:0] y_second = '0, x_third = '0, y_third = '0;
    logic [5:0] node_first = '0, node_second = '0, node_third = '0;
    logic signed [31:0] voltage = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [31:0] matrix_entry, load_entry;
    logic [1:0] status;

    txn_t pending_txns[$];
    res_t expected_results[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_sender = 1'b0;

    int stiff[64][64];
    int loads[64];

    triangle_stiffness_assembly dut (.*);

    always #4 clk = ~clk;

    function automatic longint round_div(input longint n, input longint d);
        bit neg;
        longint unsigned un, ud, q;
        neg = (n < 0) != (d < 0);
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        if (ud[0])
            q = (2 * un + ud) / (2 * ud);
        else
            q = (un + ud / 2) / ud;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic int clamp32(input longint v, inout bit flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1'b1;
            return 32'sh8000_0000;
        end
        return int'(v);
    endfunction

    function automatic res_t assemble(input txn_t t);
        res_t r;
        longint x[3], y[3], b[3], c[3], det, num, v, p;
        int nd[3], ke;
        bit sat;
        r = '{0, 0, STATUS_OK};
        sat = 1'b0;
        x = '{t.xa, t.xb, t.xc};
        y = '{t.ya, t.yb, t.yc};
        nd = '{t.na, t.nb, t.nc};
        case (mode_t'(t.mode))
            MODE_ADD:
            begin
                b = '{y[1] - y[2], y[2] - y[0], y[0] - y[1]};
                c = '{x[2] - x[1], x[0] - x[2], x[1] - x[0]};
                det = b[0] * c[1] - b[1] * c[0];
                if (det == 0)
                    r.st = STATUS_DEGEN;
                else
                begin
                    for (int i = 0; i < 3; i++)
                        for (int j = 0; j < 3; j++)
                        begin
                            num = b[i] * b[j] + c[i] * c[j];
                            ke = clamp32(round_div(num * 65536, 2 * det), sat);
                            stiff[nd[i]][nd[j]] =
                                clamp32(longint'(stiff[nd[i]][nd[j]]) + ke, sat);
                        end
                    if (sat)
                        r.st = STATUS_SAT;
                end
            end
            MODE_BOUND:
            begin
                v = t.volt;
                loads[t.na] = t.volt;
                stiff[t.na][t.na] = ONE_Q16;
                for (int j = 0; j < 64; j++)
                    if (j != t.na)
                    begin
                        p = round_div(longint'(stiff[j][t.na]) * v, 65536);
                        loads[j] = clamp32(longint'(loads[j]) - p, sat);
                        stiff[t.na][j] = 0;
                        stiff[j][t.na] = 0;
                    end
                if (sat)
                    r.st = STATUS_SAT;
            end
            MODE_READ:
            begin
                r.ld = loads[t.na];
                r.mat = stiff[t.na][t.nb];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what,
                 $signed(got), $signed(want));
        errors++;
    endtask

    always @(posedge clk)
    begin
        txn_t t;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                t = '{mode, x_first, y_first, x_second, y_second, x_third, y_third,
                      node_first, node_second, node_third, voltage};
                expected_results.push_back(assemble(t));
            end
            if (!item_valid || !item_stall)
            begin
                if (pending_txns.size() > 0 && !hold_sender
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    t = pending_txns.pop_front();
                    item_valid <= 1'b1;
                    mode <= t.mode;
                    x_first <= t.xa;
                    y_first <= t.ya;
                    x_second <= t.xb;
                    y_second <= t.yb;
                    x_third <= t.xc;
                    y_third <= t.yc;
                    node_first <= t.na;
                    node_second <= t.nb;
                    node_third <= t.nc;
                    voltage <= t.volt;
                end
                else
                    item_valid <= 1'b0;
            end
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("ERROR at %0t: result transaction with none expected", $realtime);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (matrix_entry !== e.mat)
                    report_mismatch("matrix_entry", matrix_entry, e.mat);
                if (load_entry !== e.ld)
                    report_mismatch("load_entry", load_entry, e.ld);
                if (status !== e.st)
                    report_mismatch("status", status, e.st);
            end
        end
    end

    function automatic logic signed [15:0] pick_coord(input bit wide);
        if (wide)
            return 16'($urandom);
        return 16'(int'($urandom_range(16)) - 8);
    endfunction

    function automatic txn_t random_txn();
        txn_t t;
        int sel;
        bit wide;
        sel = $urandom_range(99);
        wide = ($urandom_range(9) == 0);
        t.mode = sel < 50 ? MODE_ADD : sel < 60 ? MODE_BOUND : sel < 95 ? MODE_READ : MODE_NONE;
        t.xa = pick_coord(wide);
        t.ya = pick_coord(wide);
        t.xb = pick_coord(wide);
        t.yb = pick_coord(wide);
        t.xc = pick_coord(wide);
        t.yc = pick_coord(wide);
        if ($urandom_range(3) == 0)
        begin
            t.na = 6'($urandom);
            t.nb = 6'($urandom);
            t.nc = 6'($urandom);
        end
        else
        begin
            t.na = 6'($urandom_range(7));
            t.nb = 6'($urandom_range(7));
            t.nc = 6'($urandom_range(7));
        end
        t.volt = $urandom_range(1) ? $urandom : $signed($urandom_range(1 << 20)) - (1 << 19);
        return t;
    endfunction

    function automatic txn_t make_txn(input logic [1:0] m, input int xa, ya, xb, yb, xc, yc,
                                      input int na, nb, nc, input int v);
        txn_t t;
        t = '{m, 16'(xa), 16'(ya), 16'(xb), 16'(yb), 16'(xc), 16'(yc),
              6'(na), 6'(nb), 6'(nc), v};
        return t;
    endfunction

    task automatic drain();
        while (pending_txns.size() > 0 || item_valid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        pending_txns.push_back(make_txn(MODE_ADD, 0, 0, 1, 0, 0, 1, 0, 1, 2, 0));
        pending_txns.push_back(make_txn(MODE_ADD, 0, 0, 0, 1, 1, 0, 1, 2, 3, 0));
        pending_txns.push_back(make_txn(MODE_ADD, 3, 3, 3, 3, 3, 3, 4, 5, 6, 0));
        pending_txns.push_back(make_txn(MODE_ADD, 0, 0, 1, 1, 2, 2, 4, 5, 6, 0));
        pending_txns.push_back(make_txn(MODE_ADD, -32768, -32768, 32767, -32767, -32767,
                                        -32766, 63, 62, 61, 0));
        pending_txns.push_back(make_txn(MODE_ADD, -32768, 32767, 32767, -32768, 32767,
                                        32767, 7, 7, 7, 0));
        pending_txns.push_back(make_txn(MODE_ADD, 2, 0, 0, 5, 1, 1, 0, 0, 63, 0));
        pending_txns.push_back(make_txn(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_txns.push_back(make_txn(MODE_READ, 0, 0, 0, 0, 0, 0, 63, 62, 0, 0));
        pending_txns.push_back(make_txn(MODE_READ, 0, 0, 0, 0, 0, 0, 1, 2, 0, 0));
        pending_txns.push_back(make_txn(MODE_BOUND, 0, 0, 0, 0, 0, 0, 1, 0, 0,
                                        32'sh7FFF_FFFF));
        pending_txns.push_back(make_txn(MODE_BOUND, 0, 0, 0, 0, 0, 0, 62, 0, 0,
                                        32'sh8000_0000));
        pending_txns.push_back(make_txn(MODE_BOUND, 0, 0, 0, 0, 0, 0, 0, 0, 0, -98304));
        pending_txns.push_back(make_txn(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_txns.push_back(make_txn(MODE_READ, 0, 0, 0, 0, 0, 0, 2, 0, 0, 0));
        pending_txns.push_back(make_txn(MODE_READ, 0, 0, 0, 0, 0, 0, 63, 63, 0, 0));
        pending_txns.push_back(make_txn(MODE_NONE, -1, -1, -1, -1, -1, -1, 63, 63, 63, -1));
        pending_txns.push_back(make_txn(MODE_READ, 0, 0, 0, 0, 0, 0, 3, 1, 0, 0));
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = phase == 0 ? 16 : phase == 1 ? 81 : 0;
            recv_idle_pct = phase == 0 ? 81 : phase == 1 ? 16 : 0;
            for (int k = 0; k < 410; k++)
                pending_txns.push_back(random_txn());
            if (phase == 2)
            begin
                repeat (2000) @(posedge clk);
                hold_sender = 1'b1;
                while (item_valid || expected_results.size() > 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            drain();
        end

        repeat (600) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
